FILE: hdl/sdl_pkg.sv
// Package for the supercube diamond locator: widths, pipeline control types,
// divide-by-three and scale-control helpers, and the slot lookup table.
// No dependencies.
package sdl_pkg;

  localparam int unsigned FractionBits = 30;
  localparam int unsigned MaxExponent  = 30;
  localparam int unsigned CoordW       = 34;
  localparam int unsigned DepthW       = 8;
  localparam int unsigned LevelW       = 7;
  localparam int unsigned BlockW       = 32;
  localparam int unsigned ClassW       = 2;
  localparam int unsigned SlotW        = 6;
  localparam int unsigned LocalW       = 2;
  localparam int unsigned ShiftW       = 5;
  localparam int unsigned ExpW         = LevelW + 1;
  localparam int unsigned Lanes        = 3;
  localparam int unsigned TableDepth   = 64;
  localparam int unsigned Div3Mult     = 171;
  localparam int unsigned Div3Shift    = 9;
  localparam int unsigned Div3ProdW    = 16;

  // Per-stage load enables of the lane pipeline.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } lane_en_t;

  // Scale control: left shift when the exponent reaches the fraction width,
  // otherwise right shift by (s - 1) followed by a round-half-up step.
  typedef struct packed {
    logic              left;
    logic [ShiftW-1:0] amt;
  } shift_ctl_t;

  typedef struct packed {
    logic              valid;
    logic [ClassW-1:0] cls;
    logic [SlotW-1:0]  slot;
  } slot_entry_t;

  typedef slot_entry_t [TableDepth-1:0] slot_table_t;

  function automatic logic [LevelW-1:0] div3(input logic [DepthW-1:0] d);
    logic [Div3ProdW-1:0] p;
    p = Div3ProdW'(d) * Div3ProdW'(Div3Mult);
    return p[Div3Shift +: LevelW];
  endfunction

  function automatic shift_ctl_t shift_ctl(input logic [LevelW-1:0] level);
    logic [ExpW-1:0] lp1;
    logic [ExpW-1:0] e;
    shift_ctl_t      c;
    lp1 = {1'b0, level} + ExpW'(1);
    e   = (lp1 < ExpW'(MaxExponent)) ? lp1 : ExpW'(MaxExponent);
    if (e >= ExpW'(FractionBits)) begin
      c.left = 1'b1;
      c.amt  = ShiftW'(e - ExpW'(FractionBits));
    end else begin
      c.left = 1'b0;
      c.amt  = ShiftW'(ExpW'(FractionBits) - e - ExpW'(1));
    end
    return c;
  endfunction

  function automatic int parity_sum(input int idx);
    return ((idx >> 4) & 1) + ((idx >> 2) & 1) + (idx & 1);
  endfunction

  // Index is {x, y, z} local offsets, two bits each.
  function automatic slot_table_t build_slot_table();
    slot_table_t t;
    int          o;
    int          rank;
    int          base;
    for (int i = 0; i < TableDepth; i++) begin
      o    = parity_sum(i);
      rank = 0;
      for (int j = 0; j < i; j++) begin
        if (parity_sum(j) == o) rank++;
      end
      base = (o == 3) ? 0 : (o == 2) ? 8 : 32;
      if (o == 0) begin
        t[i] = '0;
      end else begin
        t[i].valid = 1'b1;
        t[i].cls   = ClassW'(3 - o);
        t[i].slot  = SlotW'(base + rank);
      end
    end
    return t;
  endfunction

  localparam slot_table_t SlotTable = build_slot_table();

endpackage

FILE: hdl/sdl_lane.sv
// One axis lane: magnitude, scale with rounding, sign restore; three stages.
// Depends on sdl_pkg.
module sdl_lane (
  input  logic                             clk_i,
  input  sdl_pkg::lane_en_t                en_i,
  input  logic signed [sdl_pkg::CoordW-1:0] coord_i,
  input  sdl_pkg::shift_ctl_t              shift_i,
  output logic signed [sdl_pkg::BlockW-1:0] block_o,
  output logic [sdl_pkg::LocalW-1:0]       local_o
);
  import sdl_pkg::*;

  localparam logic [CoordW-1:0] One = CoordW'(1);

  logic              neg1_q, neg2_q;
  logic [CoordW-1:0] mag1_d, mag1_q;
  logic [CoordW-1:0] shl, shr;
  logic [CoordW:0]   rsum;
  logic [CoordW-1:0] res2_d, res2_q;
  logic [CoordW-1:0] v3_d, v3_q;

  assign mag1_d = coord_i[CoordW-1] ? (~$unsigned(coord_i) + One) : $unsigned(coord_i);

  assign shl    = mag1_q << shift_i.amt;
  assign shr    = mag1_q >> shift_i.amt;
  assign rsum   = {1'b0, shr} + (CoordW+1)'(1);
  assign res2_d = shift_i.left ? shl : rsum[CoordW:1];

  assign v3_d = neg2_q ? (~res2_q + One) : res2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      neg1_q <= coord_i[CoordW-1];
      mag1_q <= mag1_d;
    end
    if (en_i.en2) begin
      neg2_q <= neg1_q;
      res2_q <= res2_d;
    end
    if (en_i.en3) begin
      v3_q <= v3_d;
    end
  end

  assign block_o = $signed(v3_q[LocalW +: BlockW]);
  assign local_o = v3_q[LocalW-1:0];

endmodule

FILE: hdl/sdl_merge.sv
// Merge stage: combines lane offsets into class and slot, output register.
// Depends on sdl_pkg.
module sdl_merge (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [sdl_pkg::LevelW-1:0]        level_i,
  input  logic signed [sdl_pkg::BlockW-1:0] block_x_i,
  input  logic signed [sdl_pkg::BlockW-1:0] block_y_i,
  input  logic signed [sdl_pkg::BlockW-1:0] block_z_i,
  input  logic [sdl_pkg::LocalW-1:0]        local_x_i,
  input  logic [sdl_pkg::LocalW-1:0]        local_y_i,
  input  logic [sdl_pkg::LocalW-1:0]        local_z_i,
  output logic [sdl_pkg::LevelW-1:0]        level_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_x_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_y_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_z_o,
  output logic [sdl_pkg::ClassW-1:0]        cube_class_o,
  output logic [sdl_pkg::SlotW-1:0]         slot_o,
  output logic                              valid_res_o
);
  import sdl_pkg::*;

  slot_entry_t entry_d, entry_q;

  assign entry_d = SlotTable[{local_x_i, local_y_i, local_z_i}];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      level_o   <= level_i;
      block_x_o <= block_x_i;
      block_y_o <= block_y_i;
      block_z_o <= block_z_i;
      entry_q   <= entry_d;
    end
  end

  assign cube_class_o = entry_q.cls;
  assign slot_o       = entry_q.slot;
  assign valid_res_o  = entry_q.valid;

endmodule

FILE: hdl/supercube_diamond_locator.sv
// Supercube diamond locator top: three axis lanes, merge stage, pipeline control.
// Pipeline: 4 register stages, three in the lanes and the last in the merge stage.
// Throughput: one item per cycle; stall passes back combinationally, bubbles fill.
// Reset: asynchronous, active low, clears the stage valid bits only.
// Depends on sdl_pkg, sdl_lane and sdl_merge.
module supercube_diamond_locator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [sdl_pkg::CoordW-1:0] centre_x_i,
  input  logic signed [sdl_pkg::CoordW-1:0] centre_y_i,
  input  logic signed [sdl_pkg::CoordW-1:0] centre_z_i,
  input  logic [sdl_pkg::DepthW-1:0]        depth_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sdl_pkg::LevelW-1:0]        level_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_x_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_y_o,
  output logic signed [sdl_pkg::BlockW-1:0] block_z_o,
  output logic [sdl_pkg::ClassW-1:0]        cube_class_o,
  output logic [sdl_pkg::SlotW-1:0]         slot_o,
  output logic                              valid_res_o
);
  import sdl_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  lane_en_t en;

  logic [LevelW-1:0] level_d, level1_q, level2_q, level3_q;
  shift_ctl_t        shift1_q;

  logic signed [BlockW-1:0] blk [Lanes];
  logic [LocalW-1:0]        loc [Lanes];
  logic signed [CoordW-1:0] coord [Lanes];

  assign adv4 = !v4_q || !out_stall_i;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_stall_o  = !adv1;
  assign out_valid_o = v4_q;

  assign en.en1 = adv1;
  assign en.en2 = adv2;
  assign en.en3 = adv3;

  assign level_d = div3(depth_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= in_valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      level1_q <= level_d;
      shift1_q <= shift_ctl(level_d);
    end
    if (adv2) level2_q <= level1_q;
    if (adv3) level3_q <= level2_q;
  end

  assign coord[0] = centre_x_i;
  assign coord[1] = centre_y_i;
  assign coord[2] = centre_z_i;

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    sdl_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .coord_i (coord[g]),
      .shift_i (shift1_q),
      .block_o (blk[g]),
      .local_o (loc[g])
    );
  end

  sdl_merge u_merge (
    .clk_i        (clk_i),
    .en_i         (adv4),
    .level_i      (level3_q),
    .block_x_i    (blk[0]),
    .block_y_i    (blk[1]),
    .block_z_i    (blk[2]),
    .local_x_i    (loc[0]),
    .local_y_i    (loc[1]),
    .local_z_i    (loc[2]),
    .level_o      (level_o),
    .block_x_o    (block_x_o),
    .block_y_o    (block_y_o),
    .block_z_o    (block_z_o),
    .cube_class_o (cube_class_o),
    .slot_o       (slot_o),
    .valid_res_o  (valid_res_o)
  );

endmodule

FILE: hdl/sdl_checker.sv
// Port-level checks for the supercube diamond locator, bound to the top level.
// Depends on sdl_pkg and supercube_diamond_locator.
module sdl_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [sdl_pkg::LevelW-1:0]        level_o,
  input logic signed [sdl_pkg::BlockW-1:0] block_x_o,
  input logic signed [sdl_pkg::BlockW-1:0] block_y_o,
  input logic signed [sdl_pkg::BlockW-1:0] block_z_o,
  input logic [sdl_pkg::ClassW-1:0]        cube_class_o,
  input logic [sdl_pkg::SlotW-1:0]         slot_o,
  input logic                              valid_res_o
);
  import sdl_pkg::*;

  // Stalled item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(level_o) &&
      $stable(block_x_o) && $stable(block_y_o) && $stable(block_z_o) &&
      $stable(cube_class_o) && $stable(slot_o) && $stable(valid_res_o))
    else $error("stalled output item changed");

  // Input side stalls only when the pipeline is full behind a stalled output.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> cube_class_o == '0 && slot_o == '0)
    else $error("invalid diamond with nonzero class or slot");

  a_class_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |->
      (cube_class_o == ClassW'(0) && slot_o < SlotW'(8)) ||
      (cube_class_o == ClassW'(1) && slot_o >= SlotW'(8) && slot_o < SlotW'(32)) ||
      (cube_class_o == ClassW'(2) && slot_o >= SlotW'(32) && slot_o < SlotW'(56)))
    else $error("class and slot group disagree");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_o <= LevelW'(85))
    else $error("level out of range");

endmodule

bind supercube_diamond_locator sdl_checker u_sdl_checker (.*);

FILE: bench/testbench.sv
// Self-checking bench for supercube_diamond_locator: directed and random centres
// against a behavioral locator, with sender gaps and receiver stalls.
// Depends on sdl_pkg and the locator RTL.
module testbench;
  import sdl_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [DepthW-1:0]        depth_t;

  typedef struct {
    logic [LevelW-1:0]        level;
    logic signed [BlockW-1:0] bx;
    logic signed [BlockW-1:0] by;
    logic signed [BlockW-1:0] bz;
    logic [ClassW-1:0]        cls;
    logic [SlotW-1:0]         slot;
    logic                     vres;
  } location_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  coord_t centre_x_i  = '0;
  coord_t centre_y_i  = '0;
  coord_t centre_z_i  = '0;
  depth_t depth_i     = '0;
  logic   out_stall_i = 1'b0;

  logic                     in_stall_o;
  logic                     out_valid_o;
  logic [LevelW-1:0]        level_o;
  logic signed [BlockW-1:0] block_x_o;
  logic signed [BlockW-1:0] block_y_o;
  logic signed [BlockW-1:0] block_z_o;
  logic [ClassW-1:0]        cube_class_o;
  logic [SlotW-1:0]         slot_o;
  logic                     valid_res_o;

  location_t expected_locations[$];
  location_t want;
  int        errors   = 0;
  int        gap_pct  = 0;
  int        stall_pct = 0;

  supercube_diamond_locator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .centre_x_i, .centre_y_i, .centre_z_i, .depth_i,
    .out_valid_o, .out_stall_i,
    .level_o, .block_x_o, .block_y_o, .block_z_o,
    .cube_class_o, .slot_o, .valid_res_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // Rounded c * 2^e / 2^FractionBits, half away from zero.
  function automatic logic signed [63:0] scale_axis(input coord_t c, input int unsigned e);
    logic signed [63:0] wide;
    logic [63:0]        mag;
    logic [63:0]        r;
    int unsigned        s;
    wide = 64'(c);
    mag  = wide[63] ? -wide : wide;
    if (e >= FractionBits) begin
      r = mag << (e - FractionBits);
    end else begin
      s = FractionBits - e;
      r = (mag + (64'd1 << (s - 1))) >> s;
    end
    return wide[63] ? -r : r;
  endfunction

  function automatic location_t locate_diamond(input coord_t cx, input coord_t cy,
                                               input coord_t cz, input depth_t d);
    location_t          loc;
    int unsigned        lvl;
    int unsigned        e;
    logic signed [63:0] vx;
    logic signed [63:0] vy;
    logic signed [63:0] vz;
    int                 lx;
    int                 ly;
    int                 lz;
    int                 odd;
    int                 rank;
    int                 base;
    lvl = d / 3;
    e   = (lvl + 1 < MaxExponent) ? lvl + 1 : MaxExponent;
    vx  = scale_axis(cx, e);
    vy  = scale_axis(cy, e);
    vz  = scale_axis(cz, e);
    loc.level = LevelW'(lvl);
    loc.bx    = vx[BlockW+1:2];
    loc.by    = vy[BlockW+1:2];
    loc.bz    = vz[BlockW+1:2];
    lx  = int'(vx[1:0]);
    ly  = int'(vy[1:0]);
    lz  = int'(vz[1:0]);
    odd = (lx % 2) + (ly % 2) + (lz % 2);
    loc.cls  = '0;
    loc.slot = '0;
    loc.vres = 1'b0;
    if (odd != 0) begin
      base = (odd == 3) ? 0 : (odd == 2) ? 8 : 32;
      rank = 0;
      for (int x = 0; x < 4; x++)
        for (int y = 0; y < 4; y++)
          for (int z = 0; z < 4; z++)
            if ((x % 2) + (y % 2) + (z % 2) == odd) begin
              if (x == lx && y == ly && z == lz) loc.slot = SlotW'(base + rank);
              rank++;
            end
      loc.cls  = ClassW'(3 - odd);
      loc.vres = 1'b1;
    end
    return loc;
  endfunction

  task automatic send_centre(input coord_t cx, input coord_t cy, input coord_t cz,
                             input depth_t d);
    logic stalled;
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    centre_x_i <= cx;
    centre_y_i <= cy;
    centre_z_i <= cz;
    depth_i    <= d;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    expected_locations.insert(expected_locations.size(), locate_diamond(cx, cy, cz, d));
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (expected_locations.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (expected_locations.size() == 0) begin
        $display("%0t unexpected item expected none actual level %0d", $time, level_o);
        errors++;
      end else begin
        want = expected_locations.pop_front();
        check_field("level", 64'(want.level), 64'(level_o));
        check_field("block_x", 64'(want.bx), 64'(block_x_o));
        check_field("block_y", 64'(want.by), 64'(block_y_o));
        check_field("block_z", 64'(want.bz), 64'(block_z_o));
        check_field("cube_class", 64'(want.cls), 64'(cube_class_o));
        check_field("slot", 64'(want.slot), 64'(slot_o));
        check_field("valid_res", 64'(want.vres), 64'(valid_res_o));
      end
    end
  end

  function automatic coord_t random_coord(input depth_t d);
    logic [63:0] r;
    int unsigned e;
    int unsigned s;
    coord_t      c;
    r = {$urandom, $urandom};
    e = (d / 3 + 1 < MaxExponent) ? d / 3 + 1 : MaxExponent;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: c = r[CoordW-1:0];
      4, 5, 6: begin
        if (e < FractionBits) begin
          s = FractionBits - e;
          c = coord_t'((r << s) | (64'd1 << (s - 1)))
              + coord_t'($signed($urandom_range(2, 0)) - 1);
        end else begin
          c = r[CoordW-1:0];
        end
        if ($urandom_range(1, 0)) c = -c;
      end
      7: c = coord_t'($signed($urandom_range(16, 0)) - 8);
      default: begin
        case ($urandom_range(3, 0))
          0: c = {1'b0, {(CoordW-1){1'b1}}};
          1: c = {1'b1, {(CoordW-1){1'b0}}};
          2: c = '0;
          default: c = '1;
        endcase
      end
    endcase
    return c;
  endfunction

  task automatic send_random_centre();
    depth_t d;
    d = (($urandom_range(3, 0) == 0) ? depth_t'($urandom_range(255, 87))
                                     : depth_t'($urandom_range(255, 0)));
    send_centre(random_coord(d), random_coord(d), random_coord(d), d);
  endtask

  task automatic test_field_extremes();
    coord_t cmax;
    coord_t cmin;
    cmax = {1'b0, {(CoordW-1){1'b1}}};
    cmin = {1'b1, {(CoordW-1){1'b0}}};
    send_centre('0, '0, '0, 8'd0);
    send_centre(cmax, cmax, cmax, 8'd255);
    send_centre(cmin, cmin, cmin, 8'd255);
    send_centre(cmax, cmin, '0, 8'd0);
    send_centre(cmin, cmax, '1, 8'd86);
    send_centre(cmax, cmin, '1, 8'd87);
    send_centre(coord_t'(34'h1_5555_5555), coord_t'(34'h2_AAAA_AAAA), cmax, 8'd3);
  endtask

  task automatic test_rounding_ties();
    send_centre(coord_t'(1 << 28), -coord_t'(1 << 28), coord_t'((1 << 28) - 1), 8'd0);
    send_centre(coord_t'(3 << 28), -coord_t'(3 << 28), -coord_t'((1 << 28) - 1), 8'd2);
    send_centre(coord_t'(1), -coord_t'(1), coord_t'(3), 8'd86);
    send_centre(coord_t'(1 << 27), -coord_t'(1 << 27), coord_t'(5 << 26), 8'd5);
  endtask

  // Depth 255 scales exactly, so the low bits are the local offsets.
  task automatic test_offset_classes();
    send_centre(coord_t'(1), coord_t'(1), coord_t'(1), 8'd255);
    send_centre(coord_t'(3), coord_t'(3), coord_t'(3), 8'd255);
    send_centre(coord_t'(1), coord_t'(3), coord_t'(0), 8'd255);
    send_centre(coord_t'(2), coord_t'(0), coord_t'(1), 8'd255);
    send_centre(coord_t'(2), coord_t'(2), coord_t'(2), 8'd255);
    send_centre(coord_t'(3), coord_t'(2), coord_t'(1), 8'd200);
    send_centre(-coord_t'(1), -coord_t'(2), -coord_t'(3), 8'd120);
    send_centre(coord_t'(6), coord_t'(5), coord_t'(7), 8'd99);
  endtask

  task automatic test_random_stream(input int count, input int gap, input int stall);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) send_random_centre();
  endtask

  task automatic test_drain_pause();
    gap_pct   = 10;
    stall_pct = 30;
    repeat (12) send_random_centre();
    wait_for_drain();
    repeat (12) send_random_centre();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_rounding_ties();
    test_offset_classes();
    test_random_stream(450, 0, 0);
    test_drain_pause();
    test_random_stream(450, 76, 0);
    test_random_stream(450, 0, 76);
    wait_for_drain();
    test_random_stream(450, 36, 36);
    wait_for_drain();
    stall_pct = 0;
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
